/* rtl/pctb_pkg.sv */
`timescale 1ns / 1ps
// pctb_pkg: shared types, codes and constants of the playlist chapter time builder
// used by every module of the block but pctb_ram, depends on nothing

package pctb_pkg;

	localparam int MAX_MARKS_DEF = 32;
	localparam int COUNT_W       = 6;
	localparam int NS_W          = 57;
	localparam int FPS_NUM_W     = 16;
	localparam int FPS_DEN_W     = 10;
	localparam int CHAP_W        = 6;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] MARK_KIND_ENTRY = 8'h01;

	// 45 kHz ticks to ns: sec = ((t >> 3) * RECIP_SEC) >> SEC_SHIFT, exact for 32-bit t
	localparam logic [29:0] RECIP_SEC     = 30'd781874936;
	localparam int          SEC_SHIFT     = 42;
	localparam logic [15:0] TICKS_PER_SEC = 16'd45000;
	// ms = ((2 * rem + 45) * RECIP_MS) >> MS_SHIFT, exact below 2^17
	localparam logic [16:0] MS_BIAS       = 17'd45;
	localparam logic [17:0] RECIP_MS      = 18'd186414;
	localparam int          MS_SHIFT      = 24;
	localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
	localparam logic [19:0] NS_PER_MS     = 20'd1000000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_PLAY  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ENTRY   = 2'd0,
		KIND_CHAPTER = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_DUR,
		ST_DWAIT,
		ST_ENTRY,
		ST_SCAN,
		ST_DECIDE,
		ST_RD,
		ST_CHK,
		ST_CWAIT,
		ST_CEMIT
	} state_t;

	typedef struct packed {
		logic [7:0]  kind;
		logic [15:0] item_ref;
		logic [31:0] stamp;
	} mark_t;

	localparam int MARK_W = $bits(mark_t);

	typedef struct packed {
		logic [31:0]        in_time;
		logic [31:0]        out_time;
		logic [4:0]         code;
		logic [15:0]        item;
		logic [COUNT_W-1:0] count;
		logic               ovf;
	} job_t;

	typedef struct packed {
		logic [FPS_NUM_W-1:0] num;
		logic [FPS_DEN_W-1:0] den;
	} fps_t;

	typedef struct packed {
		kind_t                kind;
		logic [NS_W-1:0]      duration_ns;
		logic [FPS_NUM_W-1:0] fps_numerator;
		logic [FPS_DEN_W-1:0] fps_denominator;
		logic [CHAP_W-1:0]    chapter_number;
		logic [NS_W-1:0]      chapter_time_ns;
		logic                 default_chapter;
		logic                 marks_overflowed;
		logic                 last;
	} res_t;

	function automatic fps_t fps_of(logic [3:0] code);
		fps_t r;
		r.num = '0;
		r.den = FPS_DEN_W'(1);
		case (code)
			4'd1: begin r.num = 16'd24000; r.den = 10'd1001; end
			4'd2: begin r.num = 16'd24;    r.den = 10'd1;    end
			4'd3: begin r.num = 16'd25;    r.den = 10'd1;    end
			4'd4: begin r.num = 16'd30000; r.den = 10'd1001; end
			4'd6: begin r.num = 16'd50;    r.den = 10'd1;    end
			4'd7: begin r.num = 16'd60000; r.den = 10'd1001; end
			default: begin end
		endcase
		return r;
	endfunction

endpackage

/* rtl/pctb_ram.sv */
`timescale 1ns / 1ps
// pctb_ram: generic single write port, single read port ram with registered read
// no dependencies

module pctb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/pctb_front.sv */
`timescale 1ns / 1ps
// pctb_front: accepts input transfers, keeps mark count, play item index and overflow flag
// writes the mark store and queues play item jobs; uses pctb_pkg

module pctb_front #(
	parameter int MAX_MARKS = pctb_pkg::MAX_MARKS_DEF,
	localparam int AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1,
	localparam int CW = $clog2(MAX_MARKS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         operation,
	input  logic [7:0]         mark_kind,
	input  logic [15:0]        mark_item_ref,
	input  logic [31:0]        mark_time,
	input  logic [31:0]        in_time,
	input  logic [31:0]        out_time,
	input  logic signed [4:0]  frame_rate_code,
	input  logic               back_busy,
	input  logic               q_full,
	input  logic               q_empty,
	output logic               push,
	output pctb_pkg::job_t     push_job,
	output logic               ram_we,
	output logic [AW-1:0]      ram_waddr,
	output pctb_pkg::mark_t    ram_wdata
);

	pctb_pkg::op_t   op;
	logic            take;
	logic            room;
	logic [CW-1:0]   count_q;
	logic [15:0]     index_q;
	logic            ovf_q;

	assign op = pctb_pkg::op_t'(operation);

	// store updates wait until no play item is pending
	always_comb begin
		item_stall = 1'b0;
		unique case (op) inside
			pctb_pkg::OP_CLEAR, pctb_pkg::OP_LOAD: item_stall = back_busy || !q_empty;
			pctb_pkg::OP_PLAY:                     item_stall = q_full;
			pctb_pkg::OP_NONE:                     item_stall = 1'b0;
		endcase
	end

	assign take = item_valid && !item_stall;
	assign room = count_q < CW'(MAX_MARKS);

	assign ram_we           = take && (op == pctb_pkg::OP_LOAD) && room;
	assign ram_waddr        = count_q[AW-1:0];
	assign ram_wdata.kind     = mark_kind;
	assign ram_wdata.item_ref = mark_item_ref;
	assign ram_wdata.stamp    = mark_time;

	assign push              = take && (op == pctb_pkg::OP_PLAY);
	assign push_job.in_time  = in_time;
	assign push_job.out_time = out_time;
	assign push_job.code     = frame_rate_code;
	assign push_job.item     = index_q;
	assign push_job.count    = pctb_pkg::COUNT_W'(count_q);
	assign push_job.ovf      = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			index_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			unique case (op)
				pctb_pkg::OP_CLEAR: begin
					count_q <= '0;
					index_q <= '0;
					ovf_q   <= 1'b0;
				end
				pctb_pkg::OP_LOAD: begin
					if (room) begin
						count_q <= count_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				pctb_pkg::OP_PLAY: index_q <= index_q + 16'd1;
				pctb_pkg::OP_NONE: begin end
			endcase
		end
	end

endmodule

/* rtl/pctb_queue.sv */
`timescale 1ns / 1ps
// pctb_queue: two entry job queue between front and back
// uses pctb_pkg

module pctb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pctb_pkg::job_t push_job,
	input  logic           pop,
	output pctb_pkg::job_t head,
	output logic           full,
	output logic           empty
);

	pctb_pkg::job_t mem_q [pctb_pkg::QUEUE_DEPTH];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = cnt_q == 2'(pctb_pkg::QUEUE_DEPTH);
	assign empty   = cnt_q == 2'd0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

/* rtl/pctb_conv.sv */
`timescale 1ns / 1ps
// pctb_conv: five stage pipeline turning 45 kHz ticks into ns rounded to the millisecond
// uses pctb_pkg constants

module pctb_conv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [31:0]               ticks,
	output logic                      done,
	output logic [pctb_pkg::NS_W-1:0] ns
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic [31:0] t_s1, t_s2;
	logic [58:0] prod_s2;
	logic [16:0] sec_s3;
	logic [15:0] rem_s3;
	logic [34:0] p_s4;
	logic [46:0] secns_s4;
	logic [pctb_pkg::NS_W-1:0] ns_q;
	logic        done_q;

	logic [16:0] sec;
	logic [32:0] sec_ticks;
	logic [31:0] rem_full;
	logic [16:0] ms_arg;
	logic [10:0] ms;
	logic [29:0] ms_ns;

	always_comb begin
		sec       = prod_s2[pctb_pkg::SEC_SHIFT +: 17];
		sec_ticks = 33'(sec) * 33'(pctb_pkg::TICKS_PER_SEC);
		rem_full  = t_s2 - sec_ticks[31:0];
		ms_arg    = {rem_s3, 1'b0} + pctb_pkg::MS_BIAS;
		ms        = p_s4[pctb_pkg::MS_SHIFT +: 11];
		ms_ns     = 30'(ms) * 30'(pctb_pkg::NS_PER_MS);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_s1 <= ticks;
		end
		prod_s2  <= 59'(t_s1[31:3]) * 59'(pctb_pkg::RECIP_SEC);
		t_s2     <= t_s1;
		sec_s3   <= sec;
		rem_s3   <= rem_full[15:0];
		p_s4     <= 35'(ms_arg) * 35'(pctb_pkg::RECIP_MS);
		secns_s4 <= 47'(sec_s3) * 47'(pctb_pkg::NS_PER_SEC);
		if (v_s4) begin
			ns_q <= pctb_pkg::NS_W'(secns_s4) + pctb_pkg::NS_W'(ms_ns);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	assign done = done_q;
	assign ns   = ns_q;

endmodule

/* rtl/pctb_back.sv */
`timescale 1ns / 1ps
// pctb_back: per play item sequencer, scans the mark store and issues results
// into the output register; uses pctb_pkg, drives pctb_conv and the mark store read port

module pctb_back #(
	parameter int MAX_MARKS = pctb_pkg::MAX_MARKS_DEF,
	localparam int AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1,
	localparam int CW = $clog2(MAX_MARKS + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  pctb_pkg::job_t            q_head,
	output logic                      pop,
	output logic                      busy,
	output logic                      ram_re,
	output logic [AW-1:0]             ram_raddr,
	input  pctb_pkg::mark_t           rd_mark,
	output logic                      conv_start,
	output logic [31:0]               conv_ticks,
	input  logic                      conv_done,
	input  logic [pctb_pkg::NS_W-1:0] conv_ns,
	input  logic                      result_stall,
	output logic                      result_valid,
	output pctb_pkg::res_t            result
);

	pctb_pkg::state_t state_q, state_d;
	pctb_pkg::job_t   job_q;
	pctb_pkg::res_t   res_d, res_q;
	pctb_pkg::fps_t   fps;
	logic             res_valid_q;
	logic             out_free;
	logic             emit;
	logic             hit;
	logic             chap_last;
	logic [CW-1:0]    cnt;
	logic [CW-1:0]    addr_q;
	logic             pend_q;
	logic             found_q;
	logic [CW-1:0]    first_idx_q;
	logic [31:0]      first_time_q;
	logic [CW-1:0]    matches_q;
	logic [CW-1:0]    chap_q;
	logic [31:0]      offset_q;

	assign cnt       = job_q.count[CW-1:0];
	assign out_free  = !res_valid_q || !result_stall;
	assign hit       = (rd_mark.kind == pctb_pkg::MARK_KIND_ENTRY) && (rd_mark.item_ref == job_q.item);
	assign chap_last = chap_q == matches_q;
	assign fps       = pctb_pkg::fps_of(job_q.code[3:0]);
	assign busy      = state_q != pctb_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pctb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = addr_q[AW-1:0];
		conv_start = 1'b0;
		conv_ticks = job_q.out_time - job_q.in_time;
		emit       = 1'b0;

		res_d.kind             = pctb_pkg::KIND_ENTRY;
		res_d.duration_ns      = '0;
		res_d.fps_numerator    = '0;
		res_d.fps_denominator  = pctb_pkg::FPS_DEN_W'(1);
		res_d.chapter_number   = '0;
		res_d.chapter_time_ns  = '0;
		res_d.default_chapter  = 1'b0;
		res_d.marks_overflowed = job_q.ovf;
		res_d.last             = 1'b0;

		unique case (state_q)
			pctb_pkg::ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = q_head.code[4] ? pctb_pkg::ST_ERR : pctb_pkg::ST_DUR;
				end
			end
			pctb_pkg::ST_ERR: begin
				res_d.kind = pctb_pkg::KIND_ERROR;
				res_d.last = 1'b1;
				if (out_free) begin
					emit    = 1'b1;
					state_d = pctb_pkg::ST_IDLE;
				end
			end
			pctb_pkg::ST_DUR: begin
				conv_start = 1'b1;
				state_d    = pctb_pkg::ST_DWAIT;
			end
			pctb_pkg::ST_DWAIT: begin
				if (conv_done) begin
					state_d = pctb_pkg::ST_ENTRY;
				end
			end
			pctb_pkg::ST_ENTRY: begin
				res_d.duration_ns     = conv_ns;
				res_d.fps_numerator   = fps.num;
				res_d.fps_denominator = fps.den;
				if (out_free) begin
					emit    = 1'b1;
					state_d = pctb_pkg::ST_SCAN;
				end
			end
			pctb_pkg::ST_SCAN: begin
				if (addr_q != cnt) begin
					ram_re = 1'b1;
				end else if (!pend_q) begin
					state_d = pctb_pkg::ST_DECIDE;
				end
			end
			pctb_pkg::ST_DECIDE: begin
				if (matches_q == '0) begin
					res_d.kind            = pctb_pkg::KIND_CHAPTER;
					res_d.chapter_number  = pctb_pkg::CHAP_W'(1);
					res_d.default_chapter = 1'b1;
					res_d.last            = 1'b1;
					if (out_free) begin
						emit    = 1'b1;
						state_d = pctb_pkg::ST_IDLE;
					end
				end else begin
					state_d = pctb_pkg::ST_RD;
				end
			end
			pctb_pkg::ST_RD: begin
				ram_re  = 1'b1;
				state_d = pctb_pkg::ST_CHK;
			end
			pctb_pkg::ST_CHK: begin
				if (hit) begin
					conv_start = 1'b1;
					conv_ticks = rd_mark.stamp - offset_q;
					state_d    = pctb_pkg::ST_CWAIT;
				end else begin
					state_d = pctb_pkg::ST_RD;
				end
			end
			pctb_pkg::ST_CWAIT: begin
				if (conv_done) begin
					state_d = pctb_pkg::ST_CEMIT;
				end
			end
			pctb_pkg::ST_CEMIT: begin
				res_d.kind            = pctb_pkg::KIND_CHAPTER;
				res_d.chapter_number  = pctb_pkg::CHAP_W'(chap_q);
				res_d.chapter_time_ns = conv_ns;
				res_d.last            = chap_last;
				if (out_free) begin
					emit    = 1'b1;
					state_d = chap_last ? pctb_pkg::ST_IDLE : pctb_pkg::ST_RD;
				end
			end
			default: state_d = pctb_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_head;
		end
		if (emit) begin
			res_q <= res_d;
		end
		if (state_q == pctb_pkg::ST_SCAN && pend_q && hit && !found_q) begin
			first_idx_q  <= addr_q - CW'(1);
			first_time_q <= rd_mark.stamp;
		end
		if (state_q == pctb_pkg::ST_DECIDE) begin
			offset_q <= (job_q.in_time < first_time_q) ? job_q.in_time : first_time_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			addr_q      <= '0;
			pend_q      <= 1'b0;
			found_q     <= 1'b0;
			matches_q   <= '0;
			chap_q      <= '0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				pctb_pkg::ST_DUR: begin
					addr_q    <= '0;
					pend_q    <= 1'b0;
					found_q   <= 1'b0;
					matches_q <= '0;
				end
				pctb_pkg::ST_SCAN: begin
					pend_q <= ram_re;
					if (ram_re) begin
						addr_q <= addr_q + CW'(1);
					end
					if (pend_q && hit) begin
						found_q   <= 1'b1;
						matches_q <= matches_q + CW'(1);
					end
				end
				pctb_pkg::ST_DECIDE: begin
					addr_q <= first_idx_q;
					chap_q <= CW'(1);
				end
				pctb_pkg::ST_CHK: begin
					if (!hit) begin
						addr_q <= addr_q + CW'(1);
					end
				end
				pctb_pkg::ST_CEMIT: begin
					if (out_free) begin
						addr_q <= addr_q + CW'(1);
						chap_q <= chap_q + CW'(1);
					end
				end
				default: begin end
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

/* rtl/playlist_chapter_time_builder.sv */
`timescale 1ns / 1ps
// playlist_chapter_time_builder: top level, front, job queue, back, tick converter, mark store
// uses pctb_pkg, pctb_front, pctb_queue, pctb_back, pctb_conv, pctb_ram

// Clear and load transfers are held off while a play item is queued or in progress,
// since the mark store is read by the back end. A play item with no primary video
// gives a single error result. Otherwise the back end runs the tick-to-ns pipeline
// for the duration, reads the mark store once per stored mark for the first pass,
// then re-reads from the first matching mark, running the conversion and the output
// register for each emitted chapter. The single read port of the mark store and the
// shared converter bound how fast a play item completes. Up to two play items wait in
// the job queue, and the output register lets the next result be prepared while the
// current one is stalled. No clearing pass after reset.

module playlist_chapter_time_builder #(
	parameter int MAX_MARKS = pctb_pkg::MAX_MARKS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     operation,
	input  logic [7:0]                     mark_kind,
	input  logic [15:0]                    mark_item_ref,
	input  logic [31:0]                    mark_time,
	input  logic [31:0]                    in_time,
	input  logic [31:0]                    out_time,
	input  logic signed [4:0]              frame_rate_code,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [1:0]                     kind,
	output logic [pctb_pkg::NS_W-1:0]      duration_ns,
	output logic [pctb_pkg::FPS_NUM_W-1:0] fps_numerator,
	output logic [pctb_pkg::FPS_DEN_W-1:0] fps_denominator,
	output logic [pctb_pkg::CHAP_W-1:0]    chapter_number,
	output logic [pctb_pkg::NS_W-1:0]      chapter_time_ns,
	output logic                           default_chapter,
	output logic                           marks_overflowed,
	output logic                           last
);

	localparam int AW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;

	logic                      back_busy;
	logic                      q_full;
	logic                      q_empty;
	logic                      push;
	logic                      pop;
	pctb_pkg::job_t            push_job;
	pctb_pkg::job_t            q_head;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	pctb_pkg::mark_t           ram_wdata;
	logic                      ram_re;
	logic [AW-1:0]             ram_raddr;
	pctb_pkg::mark_t           rd_mark;
	logic                      conv_start;
	logic [31:0]               conv_ticks;
	logic                      conv_done;
	logic [pctb_pkg::NS_W-1:0] conv_ns;
	pctb_pkg::res_t            result;

	pctb_front #(.MAX_MARKS(MAX_MARKS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.operation       (operation),
		.mark_kind       (mark_kind),
		.mark_item_ref   (mark_item_ref),
		.mark_time       (mark_time),
		.in_time         (in_time),
		.out_time        (out_time),
		.frame_rate_code (frame_rate_code),
		.back_busy       (back_busy),
		.q_full          (q_full),
		.q_empty         (q_empty),
		.push            (push),
		.push_job        (push_job),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata)
	);

	pctb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (q_head),
		.full     (q_full),
		.empty    (q_empty)
	);

	pctb_ram #(.WIDTH(pctb_pkg::MARK_W), .DEPTH(MAX_MARKS)) u_marks (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_mark)
	);

	pctb_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.ticks  (conv_ticks),
		.done   (conv_done),
		.ns     (conv_ns)
	);

	pctb_back #(.MAX_MARKS(MAX_MARKS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.pop          (pop),
		.busy         (back_busy),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.rd_mark      (rd_mark),
		.conv_start   (conv_start),
		.conv_ticks   (conv_ticks),
		.conv_done    (conv_done),
		.conv_ns      (conv_ns),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

	assign kind             = result.kind;
	assign duration_ns      = result.duration_ns;
	assign fps_numerator    = result.fps_numerator;
	assign fps_denominator  = result.fps_denominator;
	assign chapter_number   = result.chapter_number;
	assign chapter_time_ns  = result.chapter_time_ns;
	assign default_chapter  = result.default_chapter;
	assign marks_overflowed = result.marks_overflowed;
	assign last             = result.last;

endmodule

/* rtl/pctb_checker.sv */
`timescale 1ns / 1ps
// pctb_checker: port level assertions on the result channel of the top level
// bound to playlist_chapter_time_builder; uses pctb_pkg

module pctb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           result_valid,
	input logic                           result_stall,
	input logic [1:0]                     kind,
	input logic [pctb_pkg::NS_W-1:0]      duration_ns,
	input logic [pctb_pkg::FPS_DEN_W-1:0] fps_denominator,
	input logic [pctb_pkg::CHAP_W-1:0]    chapter_number,
	input logic                           default_chapter,
	input logic                           last
);

	// stalled transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(kind) && $stable(last) && $stable(duration_ns))
		else $error("result changed while stalled");

	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == pctb_pkg::KIND_ERROR |-> last && duration_ns == '0)
		else $error("error result not final or carries a duration");

	a_default: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && default_chapter |->
			kind == pctb_pkg::KIND_CHAPTER && chapter_number == 6'd1 && last)
		else $error("default chapter malformed");

	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == pctb_pkg::KIND_ENTRY |->
			!last && (fps_denominator == 10'd1 || fps_denominator == 10'd1001))
		else $error("entry result malformed");

endmodule

bind playlist_chapter_time_builder pctb_checker u_pctb_checker (.*);

/* dv/tb_playlist_chapter_time_builder.sv */
`timescale 1ns / 1ps
// tb_playlist_chapter_time_builder: self-checking bench for the chapter time builder
// directed rows, a 16-bit play item index wrap pass and random playlists against a shadow model
// depends on pctb_pkg and rtl/playlist_chapter_time_builder.sv

module tb_playlist_chapter_time_builder;
	import pctb_pkg::*;

	localparam int MARKS        = MAX_MARKS_DEF;
	localparam int RANDOM_ITEMS = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int LONG_HOLD    = 600;
	localparam int DRAIN_CYCLES = 400;
	localparam int REPORT_CAP   = 40;

	localparam logic [4:0] FR_RSVD_0   = 5'd0;
	localparam logic [4:0] FR_23_976   = 5'd1;
	localparam logic [4:0] FR_24       = 5'd2;
	localparam logic [4:0] FR_25       = 5'd3;
	localparam logic [4:0] FR_29_97    = 5'd4;
	localparam logic [4:0] FR_RSVD_5   = 5'd5;
	localparam logic [4:0] FR_50       = 5'd6;
	localparam logic [4:0] FR_59_94    = 5'd7;
	localparam logic [4:0] FR_RSVD_8   = 5'd8;
	localparam logic [4:0] FR_RSVD_15  = 5'd15;
	localparam logic [4:0] FR_NO_VIDEO = 5'h1F;
	localparam logic [4:0] FR_NO_VID_M = 5'h10;

	localparam logic [7:0] MARK_KIND_LINK = 8'h02;
	localparam logic [7:0] MARK_KIND_MAX  = 8'hFF;

	typedef struct {
		op_t             op;
		logic [7:0]      mk;
		logic [15:0]     mref;
		logic [31:0]     mtime;
		logic [31:0]     tin;
		logic [31:0]     tout;
		logic [4:0]      code;
		bit              pin;
		kind_t           p_kind;
		logic [NS_W-1:0] p_dur;
		logic [15:0]     p_num;
		logic [9:0]      p_den;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 item_valid;
	logic                 item_stall;
	logic [1:0]           operation;
	logic [7:0]           mark_kind;
	logic [15:0]          mark_item_ref;
	logic [31:0]          mark_time;
	logic [31:0]          in_time;
	logic [31:0]          out_time;
	logic signed [4:0]    frame_rate_code;
	logic                 result_valid;
	logic                 result_stall;
	logic [1:0]           kind;
	logic [NS_W-1:0]      duration_ns;
	logic [FPS_NUM_W-1:0] fps_numerator;
	logic [FPS_DEN_W-1:0] fps_denominator;
	logic [CHAP_W-1:0]    chapter_number;
	logic [NS_W-1:0]      chapter_time_ns;
	logic                 default_chapter;
	logic                 marks_overflowed;
	logic                 last;

	playlist_chapter_time_builder u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_valid       (item_valid),
		.item_stall       (item_stall),
		.operation        (operation),
		.mark_kind        (mark_kind),
		.mark_item_ref    (mark_item_ref),
		.mark_time        (mark_time),
		.in_time          (in_time),
		.out_time         (out_time),
		.frame_rate_code  (frame_rate_code),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.kind             (kind),
		.duration_ns      (duration_ns),
		.fps_numerator    (fps_numerator),
		.fps_denominator  (fps_denominator),
		.chapter_number   (chapter_number),
		.chapter_time_ns  (chapter_time_ns),
		.default_chapter  (default_chapter),
		.marks_overflowed (marks_overflowed),
		.last             (last)
	);

	// shadow copy of the block state
	logic [7:0]  shadow_kind  [MARKS];
	logic [15:0] shadow_ref   [MARKS];
	logic [31:0] shadow_stamp [MARKS];
	int          shadow_count;
	logic [15:0] shadow_item;
	logic        shadow_ovf;

	res_t      chapter_results_due [$];
	stim_row_t directed_rows [$];

	int mismatches;
	int transfers_in;
	int results_seen;
	int chapters_seen;
	int errors_seen;
	int ovf_seen;
	int random_sent;
	int burst_left;
	int gap_len;
	int hold_ask;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [NS_W-1:0] ticks_to_nanos(input logic [31:0] t);
		longint unsigned tt, secs, rem, ms;
		tt   = t;
		secs = tt / 64'd45000;
		rem  = tt % 64'd45000;
		ms   = (64'd2 * rem + 64'd45) / 64'd90;
		return NS_W'(secs * 64'd1000000000 + ms * 64'd1000000);
	endfunction

	function automatic res_t blank_result(input kind_t k);
		res_t r;
		r = '0;
		r.kind             = k;
		r.fps_denominator  = 10'd1;
		r.marks_overflowed = shadow_ovf;
		return r;
	endfunction

	function automatic logic [31:0] pick_ticks();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 200000));
			1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 200000));
			default: return $urandom;
		endcase
	endfunction

	function automatic stim_row_t make_row(input op_t op);
		stim_row_t s;
		s.op     = op;
		s.mk     = 8'($urandom);
		s.mref   = 16'($urandom);
		s.mtime  = $urandom;
		s.tin    = $urandom;
		s.tout   = $urandom;
		s.code   = 5'($urandom);
		s.pin    = 1'b0;
		s.p_kind = KIND_ENTRY;
		s.p_dur  = '0;
		s.p_num  = '0;
		s.p_den  = 10'd1;
		return s;
	endfunction

	function automatic stim_row_t load_row(input logic [7:0] k, input logic [15:0] r,
			input logic [31:0] t);
		stim_row_t s;
		s       = make_row(OP_LOAD);
		s.mk    = k;
		s.mref  = r;
		s.mtime = t;
		return s;
	endfunction

	function automatic stim_row_t play_row(input logic [31:0] ti, input logic [31:0] to,
			input logic [4:0] c);
		stim_row_t s;
		s      = make_row(OP_PLAY);
		s.tin  = ti;
		s.tout = to;
		s.code = c;
		return s;
	endfunction

	function automatic stim_row_t pinned(input stim_row_t s, input kind_t k,
			input logic [NS_W-1:0] d, input logic [15:0] n, input logic [9:0] q);
		stim_row_t p;
		p        = s;
		p.pin    = 1'b1;
		p.p_kind = k;
		p.p_dur  = d;
		p.p_num  = n;
		p.p_den  = q;
		return p;
	endfunction

	task automatic predict_transfer(input stim_row_t s);
		res_t        r;
		logic [15:0] item;
		logic [15:0] num;
		logic [9:0]  den;
		logic [31:0] offset;
		int          first_hit;
		int          hits;
		int          chap;
		if (s.op == OP_CLEAR) begin
			shadow_count = 0;
			shadow_item  = '0;
			shadow_ovf   = 1'b0;
		end else if (s.op == OP_LOAD) begin
			if (shadow_count < MARKS) begin
				shadow_kind[shadow_count]  = s.mk;
				shadow_ref[shadow_count]   = s.mref;
				shadow_stamp[shadow_count] = s.mtime;
				shadow_count++;
			end else begin
				shadow_ovf = 1'b1;
			end
		end else if (s.op == OP_PLAY) begin
			item        = shadow_item;
			shadow_item = shadow_item + 16'd1;
			if (s.code[4]) begin
				r      = blank_result(KIND_ERROR);
				r.last = 1'b1;
				chapter_results_due.push_back(r);
			end else begin
				num = '0;
				den = 10'd1;
				case (s.code)
					FR_23_976: begin num = 16'd24000; den = 10'd1001; end
					FR_24:     begin num = 16'd24;    den = 10'd1;    end
					FR_25:     begin num = 16'd25;    den = 10'd1;    end
					FR_29_97:  begin num = 16'd30000; den = 10'd1001; end
					FR_50:     begin num = 16'd50;    den = 10'd1;    end
					FR_59_94:  begin num = 16'd60000; den = 10'd1001; end
					default: begin end
				endcase
				first_hit = -1;
				hits      = 0;
				for (int k = 0; k < shadow_count; k++) begin
					if (shadow_kind[k] == MARK_KIND_ENTRY && shadow_ref[k] == item) begin
						if (first_hit < 0) first_hit = k;
						hits++;
					end
				end
				r                 = blank_result(KIND_ENTRY);
				r.duration_ns     = ticks_to_nanos(s.tout - s.tin);
				r.fps_numerator   = num;
				r.fps_denominator = den;
				chapter_results_due.push_back(r);
				if (hits == 0) begin
					r                 = blank_result(KIND_CHAPTER);
					r.chapter_number  = CHAP_W'(1);
					r.default_chapter = 1'b1;
					r.last            = 1'b1;
					chapter_results_due.push_back(r);
				end else begin
					offset = shadow_stamp[first_hit];
					if (s.tin < offset) offset = s.tin;
					chap = 0;
					for (int k = first_hit; k < shadow_count; k++) begin
						if (shadow_kind[k] == MARK_KIND_ENTRY && shadow_ref[k] == item) begin
							chap++;
							r                 = blank_result(KIND_CHAPTER);
							r.chapter_number  = CHAP_W'(chap);
							r.chapter_time_ns = ticks_to_nanos(shadow_stamp[k] - offset);
							r.last            = (chap == hits);
							chapter_results_due.push_back(r);
						end
					end
				end
			end
		end
	endtask

	task automatic send_transfer(input stim_row_t s);
		int   base;
		res_t r;
		@(negedge clk);
		operation       <= s.op;
		mark_kind       <= s.mk;
		mark_item_ref   <= s.mref;
		mark_time       <= s.mtime;
		in_time         <= s.tin;
		out_time        <= s.tout;
		frame_rate_code <= s.code;
		item_valid      <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		base = chapter_results_due.size();
		predict_transfer(s);
		if (s.pin && chapter_results_due.size() > base) begin
			r                 = chapter_results_due[base];
			r.kind            = s.p_kind;
			r.duration_ns     = s.p_dur;
			r.fps_numerator   = s.p_num;
			r.fps_denominator = s.p_den;
			chapter_results_due[base] = r;
		end
		transfers_in++;
		if (!quiet) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				@(negedge clk);
				item_valid <= 1'b0;
				repeat (gap_len - 1) @(negedge clk);
				burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 12);
				gap_len    = $urandom_range(1, 15);
			end
		end
	endtask

	task automatic drain_results(input int extra);
		@(negedge clk);
		item_valid <= 1'b0;
		while (chapter_results_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic random_playlist(input int n_marks);
		stim_row_t   s;
		int          n_plays;
		logic [15:0] base_item;
		logic [15:0] r;
		logic [7:0]  k;
		n_plays = $urandom_range(1, 5);
		if ($urandom_range(0, 5) != 0) begin
			send_transfer(make_row(OP_CLEAR));
			random_sent++;
		end
		base_item = shadow_item;
		repeat (n_marks) begin
			k = ($urandom_range(0, 4) != 0) ? MARK_KIND_ENTRY : 8'($urandom);
			r = ($urandom_range(0, 7) != 0) ? base_item + 16'($urandom_range(0, n_plays))
				: 16'($urandom);
			send_transfer(load_row(k, r, pick_ticks()));
			random_sent++;
			if ($urandom_range(0, 15) == 0) send_transfer(make_row(OP_NONE));
		end
		repeat (n_plays) begin
			s      = make_row(OP_PLAY);
			s.tin  = pick_ticks();
			s.tout = ($urandom_range(0, 3) != 0) ? s.tin + 32'($urandom_range(0, 900000))
				: pick_ticks();
			s.code = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(16, 31))
				: 5'($urandom_range(0, 15));
			send_transfer(s);
			random_sent++;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t due;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (kind == KIND_CHAPTER) chapters_seen++;
			if (kind == KIND_ERROR) errors_seen++;
			if (marks_overflowed) ovf_seen++;
			if (chapter_results_due.size() == 0) begin
				if (mismatches < REPORT_CAP) $error("result with none pending, kind %0d", kind);
				mismatches++;
			end else begin
				due = chapter_results_due.pop_front();
				check_field("kind", due.kind, kind);
				check_field("duration_ns", due.duration_ns, duration_ns);
				check_field("fps_numerator", due.fps_numerator, fps_numerator);
				check_field("fps_denominator", due.fps_denominator, fps_denominator);
				check_field("chapter_number", due.chapter_number, chapter_number);
				check_field("chapter_time_ns", due.chapter_time_ns, chapter_time_ns);
				check_field("default_chapter", due.default_chapter, default_chapter);
				check_field("marks_overflowed", due.marks_overflowed, marks_overflowed);
				check_field("last", due.last, last);
			end
		end
	end

	// receiver stall pattern, with a long hold on request
	initial begin : result_sink
		int mode;
		int left;
		int served;
		result_stall = 1'b0;
		mode   = 0;
		left   = 0;
		served = 0;
		wait (arst_n == 1'b1);
		forever begin
			@(negedge clk);
			if (hold_ask != served) begin
				served++;
				result_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(8, 80);
			end
			left--;
			if (quiet || mode == 0) result_stall <= 1'b0;
			else if (mode == 1) result_stall <= 1'($urandom_range(0, 1));
			else if (mode == 2) result_stall <= ($urandom_range(0, 9) < 8);
			else result_stall <= (left % 4 == 0);
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle = 0;
			else idle++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int          seq_no;
		int          n;
		stim_row_t   s;
		arst_n          = 1'b0;
		item_valid      = 1'b0;
		operation       = OP_CLEAR;
		mark_kind       = '0;
		mark_item_ref   = '0;
		mark_time       = '0;
		in_time         = '0;
		out_time        = '0;
		frame_rate_code = '0;
		shadow_count    = 0;
		shadow_item     = '0;
		shadow_ovf      = 1'b0;
		mismatches      = 0;
		transfers_in    = 0;
		results_seen    = 0;
		chapters_seen   = 0;
		errors_seen     = 0;
		ovf_seen        = 0;
		random_sent     = 0;
		burst_left      = 3;
		gap_len         = 2;
		hold_ask        = 0;
		quiet           = 1'b0;

		directed_rows.push_back(pinned(play_row(32'd0, 32'd45000, FR_23_976),
			KIND_ENTRY, NS_W'(64'd1000000000), 16'd24000, 10'd1001));
		directed_rows.push_back(pinned(play_row(32'd0, 32'd90000, FR_NO_VIDEO),
			KIND_ERROR, '0, 16'd0, 10'd1));
		directed_rows.push_back(pinned(play_row(32'hFFFF_FFFF, 32'd0, FR_NO_VID_M),
			KIND_ERROR, '0, 16'd0, 10'd1));
		directed_rows.push_back(pinned(play_row(32'd0, 32'hFFFF_FFFF, FR_59_94),
			KIND_ENTRY, NS_W'(64'd95443718000000), 16'd60000, 10'd1001));
		directed_rows.push_back(play_row(32'd5, 32'd4, FR_24));
		directed_rows.push_back(pinned(play_row(32'd0, 32'd44999, FR_25),
			KIND_ENTRY, NS_W'(64'd1000000000), 16'd25, 10'd1));
		directed_rows.push_back(play_row(32'd100, 32'd45077, FR_29_97));
		directed_rows.push_back(play_row(32'd0, 32'd44978, FR_50));
		directed_rows.push_back(pinned(play_row(32'd0, 32'd0, FR_RSVD_0),
			KIND_ENTRY, '0, 16'd0, 10'd1));
		directed_rows.push_back(pinned(play_row(32'd7, 32'd7, FR_RSVD_15),
			KIND_ENTRY, '0, 16'd0, 10'd1));
		directed_rows.push_back(play_row(32'd12345, 32'd987654, FR_RSVD_5));
		directed_rows.push_back(play_row(32'd45000, 32'd45001, FR_RSVD_8));
		directed_rows.push_back(make_row(OP_NONE));
		directed_rows.push_back(make_row(OP_CLEAR));
		directed_rows.push_back(load_row(MARK_KIND_ENTRY, 16'd0, 32'd90000));
		directed_rows.push_back(load_row(MARK_KIND_LINK, 16'd0, 32'd10));
		directed_rows.push_back(load_row(MARK_KIND_ENTRY, 16'd0, 32'd45000));
		directed_rows.push_back(load_row(MARK_KIND_ENTRY, 16'd1, 32'd1000));
		directed_rows.push_back(load_row(MARK_KIND_MAX, 16'hFFFF, 32'hFFFF_FFFF));
		directed_rows.push_back(play_row(32'd200000, 32'd300000, FR_23_976));
		directed_rows.push_back(play_row(32'd500, 32'd46000, FR_25));
		directed_rows.push_back(play_row(32'd0, 32'd1, FR_50));
		directed_rows.push_back(make_row(OP_NONE));
		directed_rows.push_back(make_row(OP_CLEAR));
		directed_rows.push_back(play_row(32'd0, 32'd45000, FR_24));

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) send_transfer(directed_rows[i]);
		drain_results(8);

		// walk the play item index through its 16-bit wrap
		quiet = 1'b1;
		send_transfer(make_row(OP_CLEAR));
		send_transfer(load_row(MARK_KIND_ENTRY, 16'hFFFF, 32'd450000));
		send_transfer(load_row(MARK_KIND_ENTRY, 16'h0000, 32'd90000));
		send_transfer(load_row(MARK_KIND_ENTRY, 16'hFFFF, 32'd900000));
		repeat (65535) send_transfer(play_row($urandom, $urandom, FR_NO_VIDEO));
		send_transfer(play_row(32'd500000, 32'd2000000, FR_23_976));
		send_transfer(play_row(32'd0, 32'd45000, FR_59_94));
		quiet = 1'b0;
		drain_results(8);

		seq_no = 0;
		while (random_sent < RANDOM_ITEMS) begin
			if (seq_no == 0) n = 35;
			else if ($urandom_range(0, 7) == 0) n = $urandom_range(28, 40);
			else n = $urandom_range(0, 6);
			if (seq_no == 3) hold_ask++;
			random_playlist(n);
			if ($urandom_range(0, 9) == 0) drain_results(4);
			seq_no++;
		end

		drain_results(DRAIN_CYCLES);
		$display("covered %0d input transfers, %0d results (%0d chapters, %0d no-video errors)",
			transfers_in, results_seen, chapters_seen, errors_seen);
		$display("%0d results carried the overflow flag, %0d mismatches", ovf_seen, mismatches);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
